// ===== hdl/vop_pkg.sv =====
// Shared types, opcodes and constants for the VGM OPL command player.
`default_nettype none
package vop_pkg;

  localparam int CMD_QUEUE_DEPTH = 4;
  localparam int RES_QUEUE_DEPTH = 2;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [7:0] OP_OPL2        = 8'h5A;
  localparam logic [7:0] OP_OPL         = 8'h5B;
  localparam logic [7:0] OP_OPL1        = 8'h5C;
  localparam logic [7:0] OP_OPL3_P0     = 8'h5E;
  localparam logic [7:0] OP_OPL3_P1     = 8'h5F;
  localparam logic [7:0] OP_OPL2_SECOND = 8'hAA;
  localparam logic [7:0] OP_OPL4        = 8'hD0;
  localparam logic [7:0] OP_WAIT        = 8'h61;
  localparam logic [7:0] OP_WAIT_735    = 8'h62;
  localparam logic [7:0] OP_WAIT_882    = 8'h63;
  localparam logic [7:0] OP_END         = 8'h66;
  localparam logic [3:0] OP_WAIT_N_HI   = 4'h7;

  localparam logic [15:0] WAIT_735_SAMPLES = 16'd735;
  localparam logic [15:0] WAIT_882_SAMPLES = 16'd882;
  localparam logic [15:0] STEP_RESET       = 16'd735;

  localparam logic [7:0] TIMER_REG_LO = 8'h02;
  localparam logic [7:0] TIMER_REG_MID = 8'h03;
  localparam logic [7:0] TIMER_REG_HI = 8'h04;
  localparam logic [7:0] REWIND_REG    = 8'h05;
  localparam logic [7:0] REWIND_VALUE  = 8'h00;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_STEP   = 2'd0,
    CFG_LENGTH = 2'd1,
    CFG_LOOP   = 2'd2
  } cfg_reg_t;

  typedef enum logic [1:0] {
    CMD_TICK   = 2'd0,
    CMD_BYTE   = 2'd1,
    CMD_REWIND = 2'd2,
    CMD_NOP    = 2'd3
  } cmd_kind_t;

  typedef enum logic [3:0] {
    OPC_WRITE_P0  = 4'd0,
    OPC_WRITE_P1  = 4'd1,
    OPC_WRITE_SEL = 4'd2,
    OPC_WAIT16    = 4'd3,
    OPC_WAIT_735  = 4'd4,
    OPC_WAIT_882  = 4'd5,
    OPC_END       = 4'd6,
    OPC_WAIT_N    = 4'd7,
    OPC_OTHER     = 4'd8
  } opc_t;

  typedef enum logic [1:0] {
    PH_OPCODE = 2'd0,
    PH_ARG1   = 2'd1,
    PH_ARG2   = 2'd2,
    PH_ARG3   = 2'd3
  } phase_t;

  typedef struct packed {
    cmd_kind_t  kind;
    opc_t       opc;
    logic [7:0] data;
  } item_t;

  typedef struct packed {
    logic        write_valid;
    logic        chip_port;
    logic [7:0]  reg_addr;
    logic [7:0]  reg_value;
    logic        want_bytes;
    logic        seek_valid;
    logic [31:0] seek_offset;
    logic        finished;
    logic [15:0] delay_left;
  } result_t;

endpackage
`default_nettype wire

// ===== hdl/vop_fifo.sv =====
// Small register queue for words between the parser stages.
`default_nettype none
module vop_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             push,
  output logic                  full,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             pop,
  output logic                  empty,
  output logic      [WIDTH-1:0] rdata
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CW'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + CW'(1);
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/vop_front.sv =====
// Front end: classifies incoming commands and stream bytes by opcode group.
`default_nettype none
module vop_front import vop_pkg::*; (
  input  wire logic [1:0] in_command,
  input  wire logic [7:0] in_stream_byte,
  output item_t           item
);

  opc_t opc;

  always_comb begin
    case (in_stream_byte)
      OP_OPL2, OP_OPL, OP_OPL1, OP_OPL3_P0: opc = OPC_WRITE_P0;
      OP_OPL3_P1, OP_OPL2_SECOND:           opc = OPC_WRITE_P1;
      OP_OPL4:                              opc = OPC_WRITE_SEL;
      OP_WAIT:                              opc = OPC_WAIT16;
      OP_WAIT_735:                          opc = OPC_WAIT_735;
      OP_WAIT_882:                          opc = OPC_WAIT_882;
      OP_END:                               opc = OPC_END;
      default: begin
        opc = (in_stream_byte[7:4] == OP_WAIT_N_HI) ? OPC_WAIT_N : OPC_OTHER;
      end
    endcase
  end

  assign item.kind = cmd_kind_t'(in_command);
  assign item.opc  = opc;
  assign item.data = in_stream_byte;

endmodule
`default_nettype wire

// ===== hdl/vop_back.sv =====
// Back end: parser state, delay counter, stream position and result build.
`default_nettype none
module vop_back import vop_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  input  wire item_t                 item,
  input  wire logic                  item_valid,
  output logic                       item_take,
  output result_t                    res,
  output logic                       res_push,
  input  wire logic                  res_full
);

  logic [15:0] step_r;
  logic [31:0] len_r;
  logic [31:0] loop_r;

  phase_t      phase_r, phase_nxt;
  opc_t        cur_r, cur_nxt;
  logic        port_nz_r, port_nz_nxt;
  logic [7:0]  reg_r, reg_nxt;
  logic [7:0]  low_r, low_nxt;
  logic [15:0] delay_r, delay_nxt;
  logic [31:0] pos_r, pos_nxt, pos_step;

  logic        fire;
  logic        done;
  logic        seek;
  logic        below;
  logic        wr_req;
  logic        wr_ok;
  logic        wr_port;
  logic [7:0]  wr_addr;
  logic [7:0]  wr_val;

  assign fire      = item_valid && !res_full;
  assign item_take = fire;
  assign res_push  = fire;

  always_comb begin
    phase_nxt = phase_r;
    case (item.kind)
      CMD_BYTE: begin
        case (phase_r)
          PH_OPCODE: begin
            if (item.opc == OPC_WRITE_P0 || item.opc == OPC_WRITE_P1 ||
                item.opc == OPC_WRITE_SEL || item.opc == OPC_WAIT16) begin
              phase_nxt = PH_ARG1;
            end
          end
          PH_ARG1: phase_nxt = PH_ARG2;
          PH_ARG2: phase_nxt = (cur_r == OPC_WRITE_SEL) ? PH_ARG3 : PH_OPCODE;
          default: phase_nxt = PH_OPCODE;
        endcase
      end
      CMD_REWIND: phase_nxt = PH_OPCODE;
      default:    phase_nxt = phase_r;
    endcase
  end

  always_comb begin
    delay_nxt   = delay_r;
    pos_step    = pos_r;
    cur_nxt     = cur_r;
    port_nz_nxt = port_nz_r;
    reg_nxt     = reg_r;
    low_nxt     = low_r;
    wr_req      = 1'b0;
    wr_port     = 1'b0;
    wr_addr     = 8'h00;
    wr_val      = 8'h00;
    done        = 1'b0;
    case (item.kind)
      CMD_TICK: begin
        if (delay_r >= step_r) begin
          delay_nxt = delay_r - step_r;
        end
      end
      CMD_BYTE: begin
        pos_step = pos_r + 32'd1;
        case (phase_r)
          PH_OPCODE: begin
            case (item.opc)
              OPC_WRITE_P0, OPC_WRITE_P1, OPC_WRITE_SEL, OPC_WAIT16: begin
                cur_nxt = item.opc;
              end
              OPC_WAIT_735: begin
                delay_nxt = WAIT_735_SAMPLES;
                done      = 1'b1;
              end
              OPC_WAIT_882: begin
                delay_nxt = WAIT_882_SAMPLES;
                done      = 1'b1;
              end
              OPC_END: begin
                pos_step = len_r;
                done     = 1'b1;
              end
              OPC_WAIT_N: begin
                delay_nxt = 16'(item.data[3:0]) + 16'd1;
                done      = 1'b1;
              end
              default: done = 1'b1;
            endcase
          end
          PH_ARG1: begin
            if (cur_r == OPC_WAIT16) begin
              low_nxt = item.data;
            end else if (cur_r == OPC_WRITE_SEL) begin
              port_nz_nxt = (item.data != 8'h00);
            end else begin
              reg_nxt = item.data;
            end
          end
          PH_ARG2: begin
            if (cur_r == OPC_WAIT16) begin
              delay_nxt = {item.data, low_r};
              done      = 1'b1;
            end else if (cur_r == OPC_WRITE_SEL) begin
              reg_nxt = item.data;
            end else begin
              wr_req  = 1'b1;
              wr_port = (cur_r == OPC_WRITE_P1);
              wr_addr = reg_r;
              wr_val  = item.data;
              done    = 1'b1;
            end
          end
          default: begin
            wr_req  = 1'b1;
            wr_port = port_nz_r;
            wr_addr = reg_r;
            wr_val  = item.data;
            done    = 1'b1;
          end
        endcase
      end
      CMD_REWIND: begin
        wr_req    = 1'b1;
        wr_port   = 1'b1;
        wr_addr   = REWIND_REG;
        wr_val    = REWIND_VALUE;
        delay_nxt = 16'd0;
        pos_step  = 32'd0;
      end
      default: begin
      end
    endcase

    seek    = done && (pos_step >= len_r) && (loop_r != 32'd0);
    pos_nxt = seek ? loop_r : pos_step;
    wr_ok   = wr_req && !(wr_addr == TIMER_REG_LO || wr_addr == TIMER_REG_MID ||
                          wr_addr == TIMER_REG_HI);
    below   = delay_nxt < step_r;

    res.write_valid = wr_ok;
    res.chip_port   = wr_ok ? wr_port : 1'b0;
    res.reg_addr    = wr_ok ? wr_addr : 8'h00;
    res.reg_value   = wr_ok ? wr_val : 8'h00;
    res.want_bytes  = below && (pos_nxt < len_r);
    res.seek_valid  = seek;
    res.seek_offset = seek ? loop_r : 32'd0;
    res.finished    = below && (pos_nxt >= len_r);
    res.delay_left  = delay_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= STEP_RESET;
      len_r  <= 32'd0;
      loop_r <= 32'd0;
    end else if (cfg_write_en) begin
      case (cfg_reg_t'(cfg_index))
        CFG_STEP:   step_r <= cfg_data[15:0];
        CFG_LENGTH: len_r  <= cfg_data;
        CFG_LOOP:   loop_r <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r   <= PH_OPCODE;
      cur_r     <= OPC_WRITE_P0;
      port_nz_r <= 1'b0;
      reg_r     <= 8'h00;
      low_r     <= 8'h00;
      delay_r   <= 16'd0;
      pos_r     <= 32'd0;
    end else if (fire) begin
      phase_r   <= phase_nxt;
      cur_r     <= cur_nxt;
      port_nz_r <= port_nz_nxt;
      reg_r     <= reg_nxt;
      low_r     <= low_nxt;
      delay_r   <= delay_nxt;
      pos_r     <= pos_nxt;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/vgm_opl_command_player.sv =====
// Top level of the VGM OPL command player: front end, queues and back end.
//
//  channel  direction  handshake            payload
//  in_      input      in_push / in_full     in_command, in_stream_byte
//  out_     output     out_pop / out_empty   write, wait and seek status word
//  cfg_     input      cfg_write_en          cfg_index, cfg_data
//
// One word in and one word out per cycle while neither queue stalls; the back
// end executes one queued word per cycle, set by the single parser state
// update, while the result queue has room. A pushed word is registered in
// the command queue, then the result queue. Reset (rst_n low, synchronous)
// empties both queues and restores registers. A full result queue stalls
// the back end; the command queue then fills and raises in_full.
`default_nettype none
module vgm_opl_command_player import vop_pkg::*; #(
  parameter int CMD_DEPTH = CMD_QUEUE_DEPTH,
  parameter int RES_DEPTH = RES_QUEUE_DEPTH
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_push,
  output logic                       in_full,
  input  wire logic [1:0]            in_command,
  input  wire logic [7:0]            in_stream_byte,
  output logic                       out_empty,
  input  wire logic                  out_pop,
  output logic                       out_write_valid,
  output logic                       out_chip_port,
  output logic [7:0]                 out_reg_addr,
  output logic [7:0]                 out_reg_value,
  output logic                       out_want_bytes,
  output logic                       out_seek_valid,
  output logic [31:0]                out_seek_offset,
  output logic                       out_finished,
  output logic [15:0]                out_delay_left,
  input  wire logic                  cfg_write_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int ITEM_W = $bits(item_t);
  localparam int RES_W  = $bits(result_t);

  item_t   front_item;
  item_t   queued_item;
  logic    cmd_empty;
  logic    item_take;
  result_t back_res;
  result_t out_res;
  logic    res_push;
  logic    res_full;

  vop_front u_front (
    .in_command     (in_command),
    .in_stream_byte (in_stream_byte),
    .item           (front_item)
  );

  vop_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (CMD_DEPTH)
  ) u_cmd_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (in_push),
    .full  (in_full),
    .wdata (front_item),
    .pop   (item_take),
    .empty (cmd_empty),
    .rdata (queued_item)
  );

  vop_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .item         (queued_item),
    .item_valid   (!cmd_empty),
    .item_take    (item_take),
    .res          (back_res),
    .res_push     (res_push),
    .res_full     (res_full)
  );

  vop_fifo #(
    .WIDTH (RES_W),
    .DEPTH (RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .full  (res_full),
    .wdata (back_res),
    .pop   (out_pop),
    .empty (out_empty),
    .rdata (out_res)
  );

  assign out_write_valid = out_res.write_valid;
  assign out_chip_port   = out_res.chip_port;
  assign out_reg_addr    = out_res.reg_addr;
  assign out_reg_value   = out_res.reg_value;
  assign out_want_bytes  = out_res.want_bytes;
  assign out_seek_valid  = out_res.seek_valid;
  assign out_seek_offset = out_res.seek_offset;
  assign out_finished    = out_res.finished;
  assign out_delay_left  = out_res.delay_left;

endmodule
`default_nettype wire

// ===== hdl/vop_checker.sv =====
// Port-level checks for the VGM OPL command player, bound to the top level.
`default_nettype none
module vop_checker import vop_pkg::*; (
  input wire logic                  clk,
  input wire logic                  rst_n,
  input wire logic                  in_full,
  input wire logic                  out_empty,
  input wire logic                  out_write_valid,
  input wire logic                  out_chip_port,
  input wire logic [7:0]            out_reg_addr,
  input wire logic [7:0]            out_reg_value,
  input wire logic                  out_want_bytes,
  input wire logic                  out_seek_valid,
  input wire logic [31:0]           out_seek_offset,
  input wire logic                  out_finished
);

  a_reset_clears: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  a_timer_suppressed: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_write_valid) |->
      (out_reg_addr != TIMER_REG_LO && out_reg_addr != TIMER_REG_MID &&
       out_reg_addr != TIMER_REG_HI))
    else $error("timer register write issued");

  a_idle_write_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_write_valid) |->
      (!out_chip_port && out_reg_addr == 8'h00 && out_reg_value == 8'h00))
    else $error("write fields set without a write");

  a_status_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> !(out_want_bytes && out_finished))
    else $error("want_bytes and finished together");

  a_seek_offset: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_seek_valid) |-> (out_seek_offset == 32'd0))
    else $error("seek offset set without a seek");

endmodule

bind vgm_opl_command_player vop_checker u_vop_checker (.*);
`default_nettype wire

// ===== dv/vgm_opl_command_player_tb.sv =====
// Self-checking testbench for the VGM OPL command player: table-driven and random streams.
`timescale 1ns / 100ps
module vgm_opl_command_player_tb;
  import vop_pkg::*;

  localparam int QUIET_LIMIT = 2000;
  localparam int HOLD_CYCLES = 60;

  typedef struct {
    bit          cfg;
    logic [15:0] step;
    logic [31:0] len;
    logic [31:0] loop;
    cmd_kind_t   cmd;
    logic [7:0]  data;
    bit          typed;
    result_t     want;
  } row_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [1:0]  in_command = CMD_NOP;
  logic [7:0]  in_stream_byte = 8'h00;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic        out_write_valid;
  logic        out_chip_port;
  logic [7:0]  out_reg_addr;
  logic [7:0]  out_reg_value;
  logic        out_want_bytes;
  logic        out_seek_valid;
  logic [31:0] out_seek_offset;
  logic        out_finished;
  logic [15:0] out_delay_left;
  logic        cfg_write_en = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = CFG_STEP;
  logic [CFG_DATA_W-1:0] cfg_data = '0;

  // player state mirror
  logic [15:0] m_step;
  logic [31:0] m_len;
  logic [31:0] m_loop;
  phase_t      m_phase;
  logic [7:0]  m_opc;
  logic [7:0]  m_port;
  logic [7:0]  m_reg;
  logic [7:0]  m_lo;
  logic [15:0] m_delay;
  logic [31:0] m_pos;

  result_t expected_words[$];
  int      errors = 0;
  bit      idle_on = 1'b1;
  bit      hold_req = 1'b0;
  int      stall = 0;
  int      quiet = 0;

  vgm_opl_command_player u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_command      (in_command),
    .in_stream_byte  (in_stream_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_write_valid (out_write_valid),
    .out_chip_port   (out_chip_port),
    .out_reg_addr    (out_reg_addr),
    .out_reg_value   (out_reg_value),
    .out_want_bytes  (out_want_bytes),
    .out_seek_valid  (out_seek_valid),
    .out_seek_offset (out_seek_offset),
    .out_finished    (out_finished),
    .out_delay_left  (out_delay_left),
    .cfg_write_en    (cfg_write_en),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic result_t play_word(cmd_kind_t k, logic [7:0] b);
    result_t    r;
    logic       done;
    logic       wr;
    logic       wp;
    logic [7:0] wa;
    logic [7:0] wv;
    logic       below;
    r = '0;
    done = 1'b0;
    wr = 1'b0;
    wp = 1'b0;
    wa = 8'h00;
    wv = 8'h00;
    case (k)
      CMD_TICK: begin
        if (m_delay >= m_step) m_delay = m_delay - m_step;
      end
      CMD_BYTE: begin
        m_pos = m_pos + 32'd1;
        done = 1'b1;
        case (m_phase)
          PH_OPCODE: begin
            case (b)
              OP_OPL2, OP_OPL, OP_OPL1, OP_OPL3_P0, OP_OPL3_P1, OP_OPL2_SECOND, OP_OPL4,
              OP_WAIT: begin
                m_opc = b;
                m_phase = PH_ARG1;
                done = 1'b0;
              end
              OP_WAIT_735: m_delay = WAIT_735_SAMPLES;
              OP_WAIT_882: m_delay = WAIT_882_SAMPLES;
              OP_END: m_pos = m_len;
              default: begin
                if (b[7:4] == OP_WAIT_N_HI) m_delay = {12'd0, b[3:0]} + 16'd1;
              end
            endcase
          end
          PH_ARG1: begin
            if (m_opc == OP_WAIT) m_lo = b;
            else if (m_opc == OP_OPL4) m_port = b;
            else m_reg = b;
            m_phase = PH_ARG2;
            done = 1'b0;
          end
          PH_ARG2: begin
            if (m_opc == OP_WAIT) begin
              m_delay = {b, m_lo};
            end else if (m_opc == OP_OPL4) begin
              m_reg = b;
              m_phase = PH_ARG3;
              done = 1'b0;
            end else begin
              wr = 1'b1;
              wp = (m_opc == OP_OPL3_P1) || (m_opc == OP_OPL2_SECOND);
              wa = m_reg;
              wv = b;
            end
          end
          default: begin
            wr = 1'b1;
            wp = (m_port != 8'h00);
            wa = m_reg;
            wv = b;
          end
        endcase
        if (done) begin
          m_phase = PH_OPCODE;
          if (m_pos >= m_len && m_loop != 32'd0) begin
            m_pos = m_loop;
            r.seek_valid = 1'b1;
            r.seek_offset = m_loop;
          end
        end
      end
      CMD_REWIND: begin
        wr = 1'b1;
        wp = 1'b1;
        wa = REWIND_REG;
        wv = REWIND_VALUE;
        m_delay = 16'd0;
        m_pos = 32'd0;
        m_phase = PH_OPCODE;
      end
      default: ;
    endcase
    if (wr && wa != TIMER_REG_LO && wa != TIMER_REG_MID && wa != TIMER_REG_HI) begin
      r.write_valid = 1'b1;
      r.chip_port = wp;
      r.reg_addr = wa;
      r.reg_value = wv;
    end
    below = m_delay < m_step;
    r.want_bytes = below && (m_pos < m_len);
    r.finished = below && (m_pos >= m_len);
    r.delay_left = m_delay;
    return r;
  endfunction

  task automatic cmp(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      $error("%s: expected %0h, got %0h", name, exp_v, act_v);
      errors++;
    end
  endtask

  task automatic check_word(result_t e, result_t a);
    cmp("write_valid", 32'(e.write_valid), 32'(a.write_valid));
    cmp("chip_port", 32'(e.chip_port), 32'(a.chip_port));
    cmp("reg_addr", 32'(e.reg_addr), 32'(a.reg_addr));
    cmp("reg_value", 32'(e.reg_value), 32'(a.reg_value));
    cmp("want_bytes", 32'(e.want_bytes), 32'(a.want_bytes));
    cmp("seek_valid", 32'(e.seek_valid), 32'(a.seek_valid));
    cmp("seek_offset", e.seek_offset, a.seek_offset);
    cmp("finished", 32'(e.finished), 32'(a.finished));
    cmp("delay_left", 32'(e.delay_left), 32'(a.delay_left));
  endtask

  task automatic push_word(cmd_kind_t k, logic [7:0] b, bit typed = 1'b0, result_t want = '0);
    result_t r;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_push <= 1'b0;
      repeat ($urandom_range(1, 12)) @(posedge clk);
    end
    in_push <= 1'b1;
    in_command <= k;
    in_stream_byte <= b;
    do @(posedge clk); while (in_full);
    r = play_word(k, b);
    expected_words.push_back(typed ? want : r);
  endtask

  task automatic settle();
    in_push <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_cfg(logic [15:0] s, logic [31:0] l, logic [31:0] lp);
    cfg_write_en <= 1'b1;
    cfg_index <= CFG_STEP;
    cfg_data <= {16'd0, s};
    @(posedge clk);
    cfg_index <= CFG_LENGTH;
    cfg_data <= l;
    @(posedge clk);
    cfg_index <= CFG_LOOP;
    cfg_data <= lp;
    @(posedge clk);
    cfg_write_en <= 1'b0;
    m_step = s;
    m_len = l;
    m_loop = lp;
  endtask

  task automatic play_random(int n);
    logic [7:0] op_list [13];
    logic [7:0] op;
    int         sent;
    int         pick;
    int         nargs;
    logic [7:0] arg;
    op_list = '{OP_OPL2, OP_OPL, OP_OPL1, OP_OPL3_P0, OP_OPL3_P1, OP_OPL2_SECOND, OP_OPL4,
                OP_WAIT, OP_WAIT_735, OP_WAIT_882, OP_END, {OP_WAIT_N_HI, 4'h0},
                {OP_WAIT_N_HI, 4'h0}};
    sent = 0;
    while (sent < n) begin
      pick = $urandom_range(0, 99);
      if (pick < 28) begin
        push_word(CMD_TICK, 8'($urandom));
        sent++;
      end else if (pick < 82) begin
        op = op_list[$urandom_range(0, 12)];
        if (op[7:4] == OP_WAIT_N_HI) op[3:0] = 4'($urandom);
        nargs = (op == OP_OPL4) ? 3 :
                (op == OP_WAIT_735 || op == OP_WAIT_882 || op == OP_END ||
                 op[7:4] == OP_WAIT_N_HI) ? 0 : 2;
        push_word(CMD_BYTE, op);
        sent++;
        for (int a = 0; a < nargs; a++) begin
          arg = 8'($urandom);
          if (op == OP_WAIT && a == 1 && $urandom_range(0, 3) != 0)
            arg = 8'($urandom_range(0, 3));
          else if (op == OP_OPL4 && a == 0 && $urandom_range(0, 1) == 0)
            arg = 8'h00;
          else if (a == nargs - 2 && op != OP_WAIT && $urandom_range(0, 7) == 0)
            arg = TIMER_REG_LO + 8'($urandom_range(0, 2));
          push_word(CMD_BYTE, arg);
          sent++;
        end
      end else if (pick < 87) begin
        push_word(CMD_REWIND, 8'($urandom));
        sent++;
      end else if (pick < 92) begin
        push_word(CMD_NOP, 8'($urandom));
        sent++;
      end else begin
        push_word(CMD_BYTE, 8'($urandom));
        sent++;
      end
    end
  endtask

  function automatic row_t row_word(cmd_kind_t c, logic [7:0] d);
    row_t r;
    r.cfg = 1'b0;
    r.step = 16'd0;
    r.len = 32'd0;
    r.loop = 32'd0;
    r.cmd = c;
    r.data = d;
    r.typed = 1'b0;
    r.want = '0;
    return r;
  endfunction

  function automatic row_t row_checked(cmd_kind_t c, logic [7:0] d, result_t w);
    row_t r;
    r = row_word(c, d);
    r.typed = 1'b1;
    r.want = w;
    return r;
  endfunction

  function automatic row_t row_setup(logic [15:0] s, logic [31:0] l, logic [31:0] lp);
    row_t r;
    r = row_word(CMD_NOP, 8'h00);
    r.cfg = 1'b1;
    r.step = s;
    r.len = l;
    r.loop = lp;
    return r;
  endfunction

  always @(posedge clk) begin
    if (rst_n && out_pop && !out_empty) begin
      if (expected_words.size() == 0) begin
        $error("result word with nothing expected");
        errors++;
      end else begin
        check_word(expected_words.pop_front(),
                   '{out_write_valid, out_chip_port, out_reg_addr, out_reg_value,
                     out_want_bytes, out_seek_valid, out_seek_offset, out_finished,
                     out_delay_left});
      end
    end
    if (hold_req) begin
      hold_req = 1'b0;
      stall = HOLD_CYCLES;
    end else if (stall == 0 && idle_on && $urandom_range(0, 5) == 0) begin
      stall = $urandom_range(1, 12);
    end
    if (stall > 0) begin
      stall--;
      out_pop <= 1'b0;
    end else begin
      out_pop <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_push && !in_full) || (out_pop && !out_empty)) begin
        quiet <= 0;
      end else if (quiet >= QUIET_LIMIT) begin
        $display("vgm_opl_command_player_tb NOT OK");
        $finish;
      end else begin
        quiet <= quiet + 1;
      end
    end
  end

  initial begin
    row_t plan[$];
    m_step = STEP_RESET;
    m_len = 32'd0;
    m_loop = 32'd0;
    m_phase = PH_OPCODE;
    m_opc = 8'h00;
    m_port = 8'h00;
    m_reg = 8'h00;
    m_lo = 8'h00;
    m_delay = 16'd0;
    m_pos = 32'd0;
    plan = '{
      row_checked(CMD_TICK, 8'h00, '{finished: 1'b1, default: '0}),
      row_checked(CMD_NOP, 8'hFF, '{finished: 1'b1, default: '0}),
      row_checked(CMD_REWIND, 8'h00, '{write_valid: 1'b1, chip_port: 1'b1,
                                      reg_addr: REWIND_REG, reg_value: REWIND_VALUE,
                                      finished: 1'b1, default: '0}),
      row_checked(CMD_BYTE, OP_WAIT_735, '{delay_left: WAIT_735_SAMPLES, default: '0}),
      row_checked(CMD_TICK, 8'hFF, '{finished: 1'b1, default: '0}),
      row_word(CMD_BYTE, OP_OPL2),
      row_word(CMD_BYTE, TIMER_REG_LO),
      row_checked(CMD_BYTE, 8'hFF, '{finished: 1'b1, default: '0}),
      row_word(CMD_BYTE, OP_OPL2_SECOND),
      row_word(CMD_BYTE, 8'hFF),
      row_word(CMD_BYTE, 8'hFF),
      row_word(CMD_BYTE, OP_OPL4),
      row_word(CMD_BYTE, 8'h00),
      row_word(CMD_BYTE, 8'h20),
      row_word(CMD_BYTE, 8'h5A),
      row_word(CMD_BYTE, OP_OPL4),
      row_word(CMD_BYTE, 8'hFF),
      row_word(CMD_BYTE, TIMER_REG_HI),
      row_word(CMD_BYTE, 8'h00),
      row_setup(16'd1, 32'd40, 32'd3),
      row_word(CMD_BYTE, OP_WAIT),
      row_word(CMD_BYTE, 8'hFF),
      row_word(CMD_BYTE, 8'hFF),
      row_word(CMD_BYTE, {OP_WAIT_N_HI, 4'hF}),
      row_word(CMD_BYTE, OP_WAIT_882),
      row_word(CMD_BYTE, 8'hFF),
      row_word(CMD_BYTE, OP_END),
      row_setup(16'hFFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF),
      row_word(CMD_BYTE, OP_END),
      row_word(CMD_BYTE, OP_WAIT_735),
      row_word(CMD_TICK, 8'h00)
    };
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (plan[i]) begin
      if (plan[i].cfg) begin
        settle();
        write_cfg(plan[i].step, plan[i].len, plan[i].loop);
      end else begin
        push_word(plan[i].cmd, plan[i].data, plan[i].typed, plan[i].want);
      end
    end
    settle();
    write_cfg(STEP_RESET, 32'd48, 32'd7);
    hold_req = 1'b1;
    play_random(120);
    settle();
    write_cfg(16'd1, 32'd0, 32'd0);
    play_random(80);
    settle();
    write_cfg(16'hFFFF, 32'hFFFF_FFFF, 32'd0);
    play_random(60);
    settle();
    write_cfg(16'($urandom_range(2, 3000)), 32'($urandom_range(20, 300)),
              ($urandom_range(0, 1) == 0) ? $urandom : 32'($urandom_range(1, 40)));
    play_random(120);
    settle();
    idle_on = 1'b0;
    write_cfg(WAIT_882_SAMPLES, 32'd100, 32'd1);
    play_random(80);
    settle();
    if (errors == 0) begin
      $display("vgm_opl_command_player_tb OK");
    end else begin
      $display("vgm_opl_command_player_tb NOT OK");
    end
    $finish;
  end

endmodule
